FILE: hdl/owsr_pkg.sv
// Shared types, constants and per-cell step function for the omni wheel speed resolver.
package owsr_pkg;

    // Field widths.
    localparam int unsigned SPEED_BITS = 16;
    localparam int unsigned ANGLE_BITS = 16;
    localparam int unsigned FRAC_BITS  = ANGLE_BITS - 2;

    // Internal datapath widths, derived from the field widths and the fixed Q30, trig and gain widths.
    localparam int unsigned Q30_W   = 31;
    localparam int unsigned TRIG_W  = 16;
    localparam int unsigned PROD_W  = SPEED_BITS + TRIG_W;
    localparam int unsigned ROT_W   = PROD_W + 1;
    localparam int unsigned SUM_W   = PROD_W + 2;
    localparam int unsigned GAIN_W  = 16;
    localparam int unsigned MIX_W   = SUM_W + GAIN_W;
    localparam int unsigned WIDE_W  = (MIX_W > 64) ? MIX_W : 64;
    localparam int unsigned TOT_W   = WIDE_W + 1;
    localparam int unsigned WHOLE_W = TOT_W - 30;

    localparam int unsigned NUM_LANES  = 2;
    localparam int unsigned NUM_WHEELS = 4;

    // Lane, product and wheel indexes.
    localparam int unsigned LANE_SIN = 0;
    localparam int unsigned LANE_COS = 1;
    localparam int unsigned PROD_XC  = 0;
    localparam int unsigned PROD_YS  = 1;
    localparam int unsigned PROD_XS  = 2;
    localparam int unsigned PROD_YC  = 3;
    localparam int unsigned WHEEL_A  = 0;
    localparam int unsigned WHEEL_B  = 1;
    localparam int unsigned WHEEL_C  = 2;
    localparam int unsigned WHEEL_D  = 3;

    // Work done by each cell of the chain, in order.
    localparam int unsigned STEP_PHASE   = 0;
    localparam int unsigned STEP_HORNER7 = 1;
    localparam int unsigned STEP_HORNER5 = 2;
    localparam int unsigned STEP_HORNER3 = 3;
    localparam int unsigned STEP_HORNER1 = 4;
    localparam int unsigned STEP_TRIG    = 5;
    localparam int unsigned STEP_ROT     = 6;
    localparam int unsigned STEP_AXIS    = 7;
    localparam int unsigned STEP_SUM     = 8;
    localparam int unsigned STEP_MIX     = 9;
    localparam int unsigned STEP_SPIN    = 10;
    localparam int unsigned STEP_SAT     = 11;
    localparam int unsigned NUM_STEPS    = 12;

    // Sine polynomial coefficients in Q30.
    localparam logic [Q30_W-1:0] Q30_ONE = 31'h4000_0000;
    localparam logic [Q30_W-1:0] COEF_C1 = 31'd1686629713;
    localparam logic [Q30_W-1:0] COEF_C3 = 31'd693598668;
    localparam logic [Q30_W-1:0] COEF_C5 = 31'd85569306;
    localparam logic [Q30_W-1:0] COEF_C7 = 31'd5026995;
    localparam logic [Q30_W-1:0] COEF_C9 = 31'd172272;

    localparam logic [ANGLE_BITS-1:0] ANGLE_QUARTER = {2'b01, {FRAC_BITS{1'b0}}};
    localparam logic [31:0]           Q15_HALF      = 32'd16384;
    localparam logic [TRIG_W-1:0]     TRIG_MAX      = 16'd32767;
    localparam logic signed [GAIN_W-1:0] INV_SQRT2  = 16'sd23170;

    localparam logic signed [WIDE_W-1:0] MIX_LIM   = WIDE_W'(64'h4000_0000_0000_0000);
    localparam logic signed [WIDE_W-1:0] MIX_LIM_N = -MIX_LIM;
    localparam logic signed [TOT_W-1:0]  TRUNC_BIAS = TOT_W'(32'h3FFF_FFFF);

    localparam longint SPD_MAX = (longint'(1) <<< (SPEED_BITS - 1)) - 1;
    localparam longint SPD_MIN = -SPD_MAX - 1;

    // Scalar types.
    typedef logic signed [SPEED_BITS-1:0] speed_t;
    typedef logic signed [ANGLE_BITS-1:0] angle_t;
    typedef logic [Q30_W-1:0]             q30_t;
    typedef logic signed [TRIG_W-1:0]     trig_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [ROT_W-1:0]      rot_t;
    typedef logic signed [SUM_W-1:0]      sum_t;
    typedef logic signed [MIX_W-1:0]      mix_t;
    typedef logic signed [TOT_W-1:0]      tot_t;

    // Command word on the input channel.
    typedef struct packed {
        speed_t vel_x;
        speed_t vel_y;
        speed_t vel_spin;
        angle_t yaw_angle;
    } owsr_cmd_t;

    // Wheel target word on the output channel.
    typedef struct packed {
        speed_t wheel_speed_a;
        speed_t wheel_speed_b;
        speed_t wheel_speed_c;
        speed_t wheel_speed_d;
    } owsr_wheel_t;

    // One sine evaluation lane.
    typedef struct packed {
        logic [1:0] quad;
        q30_t       x;
        q30_t       x2;
        q30_t       t;
    } owsr_lane_t;

    // Word carried from cell to cell.
    typedef struct packed {
        owsr_cmd_t                    cmd;
        owsr_lane_t [NUM_LANES-1:0]   lane;
        trig_t [NUM_LANES-1:0]        trig;
        prod_t [3:0]                  prod;
        rot_t                         xr;
        rot_t                         yr;
        sum_t [NUM_WHEELS-1:0]        sum;
        mix_t [NUM_WHEELS-1:0]        mix;
        tot_t [NUM_WHEELS-1:0]        tot;
        speed_t [NUM_WHEELS-1:0]      speed;
    } owsr_work_t;

    // One Horner step: c - floor(x2 * t / 2^30).
    function automatic q30_t owsr_horner(input q30_t x2, input q30_t t, input q30_t c);
        logic [2*Q30_W-1:0] prod_u;
        logic [Q30_W:0]     shifted;
        prod_u  = {{Q30_W{1'b0}}, x2} * {{Q30_W{1'b0}}, t};
        shifted = prod_u[30 +: Q30_W+1];
        return Q30_W'({1'b0, c} - shifted);
    endfunction

    // The work of one cell, selected by its position in the chain.
    function automatic owsr_work_t owsr_step(input int unsigned step, input owsr_work_t w_in);
        owsr_work_t          w;
        logic [ANGLE_BITS-1:0] phase;
        logic [FRAC_BITS-1:0]  frac;
        q30_t                xq;
        logic [2*Q30_W-1:0]  prod_u;
        logic [31:0]         rounded;
        logic [16:0]         mag;
        trig_t               mag16;
        logic signed [WIDE_W-1:0] wide;
        tot_t                spin_q30;
        tot_t                biased;
        logic signed [WHOLE_W-1:0] whole;
        w = w_in;
        case (step)
            STEP_PHASE:
            begin
                // Split each phase into quadrant and Q30 fraction, then square it.
                for (int i = 0; i < NUM_LANES; i++)
                begin
                    phase = w.cmd.yaw_angle;
                    if (i == LANE_COS)
                    begin
                        phase = phase + ANGLE_QUARTER;
                    end
                    frac = phase[FRAC_BITS-1:0];
                    xq   = {1'b0, frac, {(30 - FRAC_BITS){1'b0}}};
                    if (phase[ANGLE_BITS-2])
                    begin
                        xq = Q30_ONE - xq;
                    end
                    prod_u           = {{Q30_W{1'b0}}, xq} * {{Q30_W{1'b0}}, xq};
                    w.lane[i].quad   = phase[ANGLE_BITS-1 -: 2];
                    w.lane[i].x      = xq;
                    w.lane[i].x2     = prod_u[30 +: Q30_W];
                end
            end
            STEP_HORNER7:
            begin
                for (int i = 0; i < NUM_LANES; i++)
                begin
                    w.lane[i].t = owsr_horner(w.lane[i].x2, COEF_C9, COEF_C7);
                end
            end
            STEP_HORNER5:
            begin
                for (int i = 0; i < NUM_LANES; i++)
                begin
                    w.lane[i].t = owsr_horner(w.lane[i].x2, w.lane[i].t, COEF_C5);
                end
            end
            STEP_HORNER3:
            begin
                for (int i = 0; i < NUM_LANES; i++)
                begin
                    w.lane[i].t = owsr_horner(w.lane[i].x2, w.lane[i].t, COEF_C3);
                end
            end
            STEP_HORNER1:
            begin
                for (int i = 0; i < NUM_LANES; i++)
                begin
                    w.lane[i].t = owsr_horner(w.lane[i].x2, w.lane[i].t, COEF_C1);
                end
            end
            STEP_TRIG:
            begin
                // Final odd term, round half up to Q15, cap and apply the quadrant sign.
                for (int i = 0; i < NUM_LANES; i++)
                begin
                    prod_u  = {{Q30_W{1'b0}}, w.lane[i].x} * {{Q30_W{1'b0}}, w.lane[i].t};
                    rounded = prod_u[30 +: 32] + Q15_HALF;
                    mag     = rounded[31:15];
                    if (mag > {1'b0, TRIG_MAX})
                    begin
                        mag16 = TRIG_MAX;
                    end
                    else
                    begin
                        mag16 = mag[TRIG_W-1:0];
                    end
                    w.trig[i] = w.lane[i].quad[1] ? -mag16 : mag16;
                end
            end
            STEP_ROT:
            begin
                // Four rotation products in parallel.
                w.prod[PROD_XC] = prod_t'($signed(w.cmd.vel_x)) *
                                  prod_t'($signed(w.trig[LANE_COS]));
                w.prod[PROD_YS] = prod_t'($signed(w.cmd.vel_y)) *
                                  prod_t'($signed(w.trig[LANE_SIN]));
                w.prod[PROD_XS] = prod_t'($signed(w.cmd.vel_x)) *
                                  prod_t'($signed(w.trig[LANE_SIN]));
                w.prod[PROD_YC] = prod_t'($signed(w.cmd.vel_y)) *
                                  prod_t'($signed(w.trig[LANE_COS]));
            end
            STEP_AXIS:
            begin
                w.xr = rot_t'($signed(w.prod[PROD_XC])) - rot_t'($signed(w.prod[PROD_YS]));
                w.yr = rot_t'($signed(w.prod[PROD_XS])) + rot_t'($signed(w.prod[PROD_YC]));
            end
            STEP_SUM:
            begin
                w.sum[WHEEL_A] = sum_t'($signed(w.xr)) + sum_t'($signed(w.yr));
                w.sum[WHEEL_B] = sum_t'($signed(w.yr)) - sum_t'($signed(w.xr));
                w.sum[WHEEL_C] = -sum_t'($signed(w.xr)) - sum_t'($signed(w.yr));
                w.sum[WHEEL_D] = sum_t'($signed(w.xr)) - sum_t'($signed(w.yr));
            end
            STEP_MIX:
            begin
                for (int i = 0; i < NUM_WHEELS; i++)
                begin
                    w.mix[i] = mix_t'($signed(w.sum[i])) * mix_t'(INV_SQRT2);
                end
            end
            STEP_SPIN:
            begin
                // Clamp the mixed term, then add the spin term in Q30.
                spin_q30 = tot_t'($signed(w.cmd.vel_spin));
                spin_q30 = spin_q30 <<< 30;
                for (int i = 0; i < NUM_WHEELS; i++)
                begin
                    wide = WIDE_W'($signed(w.mix[i]));
                    if (wide > MIX_LIM)
                    begin
                        wide = MIX_LIM;
                    end
                    else if (wide < MIX_LIM_N)
                    begin
                        wide = MIX_LIM_N;
                    end
                    w.tot[i] = tot_t'(wide) + spin_q30;
                end
            end
            STEP_SAT:
            begin
                // Truncate toward zero, then saturate to the speed range.
                for (int i = 0; i < NUM_WHEELS; i++)
                begin
                    biased = w.tot[i][TOT_W-1] ? (w.tot[i] + TRUNC_BIAS) : w.tot[i];
                    whole  = biased[TOT_W-1:30];
                    if (longint'(whole) > SPD_MAX)
                    begin
                        w.speed[i] = SPEED_BITS'(SPD_MAX);
                    end
                    else if (longint'(whole) < SPD_MIN)
                    begin
                        w.speed[i] = SPEED_BITS'(SPD_MIN);
                    end
                    else
                    begin
                        w.speed[i] = whole[SPEED_BITS-1:0];
                    end
                end
            end
            default:
            begin
                w = w_in;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: hdl/owsr_cell.sv
// One cell of the resolver chain: a handshake stage that applies its step to the word.
module owsr_cell #(
    parameter int unsigned STEP = owsr_pkg::STEP_PHASE
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  owsr_pkg::owsr_work_t up_work,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output owsr_pkg::owsr_work_t dn_work
);
    import owsr_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    owsr_work_t work_reg;
    owsr_work_t work_next;
    logic       load;

    // The cell takes a word when it is empty or its word moves on this cycle.
    assign up_ready = !valid_reg || dn_ready;
    assign load     = up_valid && up_ready;

    // Next occupancy and next word.
    always_comb
    begin
        valid_next = up_ready ? up_valid : valid_reg;
        work_next  = load ? owsr_step(STEP, up_work) : work_reg;
    end

    // Occupancy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Word register.
    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
    end

    assign dn_valid = valid_reg;
    assign dn_work  = work_reg;

endmodule

FILE: hdl/omni_wheel_speed_resolver_unit.sv
// Top level of the omni wheel speed resolver: a chain of twelve cells from command to wheel targets.
//
// Each command word (vel_x, vel_y, vel_spin, yaw_angle) yields one wheel word with four saturated
// wheel targets. The datapath is a chain of twelve cells, one per arithmetic step: phase split and
// squaring, four Horner steps of the sine polynomial for sine and cosine side by side, Q15
// rounding, the rotation products, the two axis sums, the four wheel sums, the 1/sqrt2 gain, the
// clamp and spin add, and finally truncation and saturation. Every cell holds one word, so the
// block takes a new command every cycle while the output is not stalled. A result passes through
// all twelve cell registers before it is presented, and is taken when wheel_ready is high.
// The number of cells is set by the one multiplier per lane allowed
// in each cell. The last cell is the output register; cmd_ready is high whenever the first cell
// is empty or the chain can move, so empty cells close up while the output waits.
module omni_wheel_speed_resolver_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  owsr_pkg::owsr_cmd_t   cmd,
    output logic                  wheel_valid,
    input  logic                  wheel_ready,
    output owsr_pkg::owsr_wheel_t wheel
);
    import owsr_pkg::*;

    logic [NUM_STEPS:0] link_valid;
    logic [NUM_STEPS:0] link_ready;
    owsr_work_t         link_work [NUM_STEPS+1];

    // Load the command into an otherwise empty work word.
    always_comb
    begin
        link_work[0]     = '0;
        link_work[0].cmd = cmd;
    end

    assign link_valid[0] = cmd_valid;
    assign cmd_ready     = link_ready[0];

    // The chain of cells.
    for (genvar k = 0; k < NUM_STEPS; k++)
    begin : g_cell
        owsr_cell #(
            .STEP(k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (link_valid[k]),
            .up_ready (link_ready[k]),
            .up_work  (link_work[k]),
            .dn_valid (link_valid[k+1]),
            .dn_ready (link_ready[k+1]),
            .dn_work  (link_work[k+1])
        );
    end

    // Output channel straight from the last cell.
    assign wheel_valid          = link_valid[NUM_STEPS];
    assign link_ready[NUM_STEPS] = wheel_ready;

    always_comb
    begin
        wheel.wheel_speed_a = link_work[NUM_STEPS].speed[WHEEL_A];
        wheel.wheel_speed_b = link_work[NUM_STEPS].speed[WHEEL_B];
        wheel.wheel_speed_c = link_work[NUM_STEPS].speed[WHEEL_C];
        wheel.wheel_speed_d = link_work[NUM_STEPS].speed[WHEEL_D];
    end

`ifndef NO_ASSERTIONS
    // A full chain with a stalled output must refuse new commands.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ((&link_valid[NUM_STEPS:1]) && !wheel_ready) |-> !cmd_ready)
        else $error("command accepted into a full, stalled chain");

    // The cosine lane runs exactly one quadrant ahead of the sine lane.
    a_quad_offset: assert property (@(posedge clk) disable iff (!rst_n)
        link_valid[STEP_PHASE+1] |->
            (link_work[STEP_PHASE+1].lane[LANE_COS].quad ==
             2'(link_work[STEP_PHASE+1].lane[LANE_SIN].quad + 2'd1)))
        else $error("cosine quadrant is not one ahead of sine quadrant");

    // Rounded sine and cosine never reach the most negative Q15 code.
    a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
        link_valid[STEP_TRIG+1] |->
            ((link_work[STEP_TRIG+1].trig[LANE_SIN] != {1'b1, {(TRIG_W-1){1'b0}}}) &&
             (link_work[STEP_TRIG+1].trig[LANE_COS] != {1'b1, {(TRIG_W-1){1'b0}}})))
        else $error("trig value out of Q15 range");

    // Opposite wheels get mixed terms of equal size and opposite sign.
    a_mix_mirror: assert property (@(posedge clk) disable iff (!rst_n)
        link_valid[STEP_MIX+1] |->
            (($signed(link_work[STEP_MIX+1].mix[WHEEL_A]) ==
              -$signed(link_work[STEP_MIX+1].mix[WHEEL_C])) &&
             ($signed(link_work[STEP_MIX+1].mix[WHEEL_B]) ==
              -$signed(link_work[STEP_MIX+1].mix[WHEEL_D]))))
        else $error("mixed terms of opposite wheels do not mirror");
`endif

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the omni wheel speed resolver unit.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import owsr_pkg::*;

    // Sine polynomial coefficients (Q30) and the 1/sqrt2 gain (Q15).
    localparam longint unsigned SIN_K1 = 64'd1686629713;
    localparam longint unsigned SIN_K3 = 64'd693598668;
    localparam longint unsigned SIN_K5 = 64'd85569306;
    localparam longint unsigned SIN_K7 = 64'd5026995;
    localparam longint unsigned SIN_K9 = 64'd172272;
    localparam longint unsigned UNIT_Q30 = 64'd1 << 30;
    localparam longint ROOT_HALF_Q15 = 23170;
    localparam longint MIXED_CAP = 64'sd1 <<< 62;
    localparam longint SPEED_HI = (64'sd1 <<< (SPEED_BITS - 1)) - 1;
    localparam longint SPEED_LO = -SPEED_HI - 1;
    localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = 1 << (ANGLE_BITS - 2);
    localparam int RANDOM_WORDS = 900;
    localparam int STALL_LIMIT = 4000;

    // Scoreboard: turns each accepted command into its wheel targets and checks results.
    class wheel_scoreboard;
        owsr_wheel_t pending_wheels[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        // Q1.15 sine of a phase in fractions of a full turn.
        function int sine_q15(logic [ANGLE_BITS-1:0] phase);
            longint unsigned x, x2, t, s, r;
            x = longint'(phase[FRAC_BITS-1:0]) << (32 - ANGLE_BITS);
            if (phase[ANGLE_BITS-2])
            begin
                x = UNIT_Q30 - x;
            end
            x2 = (x * x) >> 30;
            t = SIN_K7 - ((x2 * SIN_K9) >> 30);
            t = SIN_K5 - ((x2 * t) >> 30);
            t = SIN_K3 - ((x2 * t) >> 30);
            t = SIN_K1 - ((x2 * t) >> 30);
            s = (x * t) >> 30;
            r = (s + 64'd16384) >> 15;
            if (r > 64'd32767)
            begin
                r = 64'd32767;
            end
            return phase[ANGLE_BITS-1] ? -int'(r) : int'(r);
        endfunction

        // One wheel: scale the Q15 sum by 1/sqrt2, clamp, add spin, truncate toward zero, saturate.
        function speed_t wheel_target(longint sum_q15, longint spin);
            longint p, total, r;
            p = sum_q15 * ROOT_HALF_Q15;
            if (p > MIXED_CAP)
            begin
                p = MIXED_CAP;
            end
            if (p < -MIXED_CAP)
            begin
                p = -MIXED_CAP;
            end
            total = p + (spin <<< 30);
            if (total >= 0)
            begin
                r = total >>> 30;
            end
            else
            begin
                r = -((-total) >>> 30);
            end
            if (r > SPEED_HI)
            begin
                r = SPEED_HI;
            end
            if (r < SPEED_LO)
            begin
                r = SPEED_LO;
            end
            return speed_t'(r);
        endfunction

        // Rotate the linear velocity by the yaw angle and mix into four wheels.
        function owsr_wheel_t resolve(owsr_cmd_t c);
            owsr_wheel_t w;
            longint vx, vy, spin, sn, cs, xr, yr;
            logic [ANGLE_BITS-1:0] cos_phase;
            vx = c.vel_x;
            vy = c.vel_y;
            spin = c.vel_spin;
            cos_phase = c.yaw_angle + QUARTER_TURN;
            sn = sine_q15(c.yaw_angle);
            cs = sine_q15(cos_phase);
            xr = vx * cs - vy * sn;
            yr = vx * sn + vy * cs;
            w.wheel_speed_a = wheel_target(xr + yr, spin);
            w.wheel_speed_b = wheel_target(-xr + yr, spin);
            w.wheel_speed_c = wheel_target(-xr - yr, spin);
            w.wheel_speed_d = wheel_target(xr - yr, spin);
            return w;
        endfunction

        function void note_cmd(owsr_cmd_t c);
            pending_wheels.push_back(resolve(c));
        endfunction

        function int field_mismatch(string name, speed_t want, speed_t got);
            if (want !== got)
            begin
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
                return 1;
            end
            return 0;
        endfunction

        function void check_wheel(owsr_wheel_t got);
            owsr_wheel_t want;
            if (pending_wheels.size() == 0)
            begin
                $display("%0t: unexpected wheel word, expected none got %h", $time, got);
                errors++;
                return;
            end
            want = pending_wheels.pop_front();
            errors += field_mismatch("wheel_speed_a", want.wheel_speed_a, got.wheel_speed_a);
            errors += field_mismatch("wheel_speed_b", want.wheel_speed_b, got.wheel_speed_b);
            errors += field_mismatch("wheel_speed_c", want.wheel_speed_c, got.wheel_speed_c);
            errors += field_mismatch("wheel_speed_d", want.wheel_speed_d, got.wheel_speed_d);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    owsr_cmd_t cmd = '0;
    logic wheel_valid;
    logic wheel_ready = 1'b0;
    owsr_wheel_t wheel;

    wheel_scoreboard sb;
    bit no_idle = 1'b0;
    int quiet_cycles = 0;

    omni_wheel_speed_resolver_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .wheel_valid (wheel_valid),
        .wheel_ready (wheel_ready),
        .wheel       (wheel)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Gap before a command word: mostly none or short, now and then long.
    function int sender_gap();
        int r;
        if (no_idle)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        else if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        else if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // A speed value that favors the range limits and small values.
    function speed_t edgy_speed();
        case ($urandom_range(0, 6))
            0: return speed_t'(SPEED_HI);
            1: return speed_t'(SPEED_LO);
            2: return '0;
            3: return speed_t'(-1);
            4: return speed_t'($urandom_range(0, 7)) - speed_t'(3);
            default: return speed_t'($urandom);
        endcase
    endfunction

    function owsr_cmd_t make_cmd(longint x, longint y, longint spin, longint ang);
        owsr_cmd_t c;
        c.vel_x = speed_t'(x);
        c.vel_y = speed_t'(y);
        c.vel_spin = speed_t'(spin);
        c.yaw_angle = angle_t'(ang);
        return c;
    endfunction

    // Present one command word and hold it until it is taken.
    task automatic send_cmd(input owsr_cmd_t c);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd <= c;
        cmd_valid <= 1'b1;
        do @(posedge clk); while (!cmd_ready);
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (sb.pending_wheels.size() != 0);
    endtask

    // Note accepted commands and check accepted wheel words.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready)
            begin
                sb.note_cmd(cmd);
            end
            if (wheel_valid && wheel_ready)
            begin
                sb.check_wheel(wheel);
            end
        end
    end

    // Watchdog on cycles in which no word moves on either channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && cmd_ready) || (wheel_valid && wheel_ready))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

    // Output side: ready in runs of random length with stalls in between.
    initial
    begin : receiver
        int run;
        int gap;
        int r;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            run = (r < 10) ? $urandom_range(50, 200) : $urandom_range(1, 8);
            wheel_ready <= 1'b1;
            repeat (run) @(posedge clk);
            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                gap = 0;
            end
            else if (r < 65)
            begin
                gap = $urandom_range(1, 2);
            end
            else if (r < 92)
            begin
                gap = $urandom_range(3, 8);
            end
            else
            begin
                gap = $urandom_range(20, 80);
            end
            if (gap > 0)
            begin
                wheel_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        owsr_cmd_t c;
        int r;
        int q;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words: range limits, quadrant boundaries, saturation and truncation.
        send_cmd(make_cmd(0, 0, 0, 0));
        send_cmd(make_cmd(32767, 32767, 32767, 0));
        send_cmd(make_cmd(-32768, -32768, -32768, 0));
        send_cmd(make_cmd(32767, -32768, 0, 16384));
        send_cmd(make_cmd(-32768, 32767, 0, -32768));
        send_cmd(make_cmd(32767, 0, 0, -16384));
        send_cmd(make_cmd(0, 32767, -32768, 1));
        send_cmd(make_cmd(1000, -2000, 300, -1));
        send_cmd(make_cmd(32767, 32767, 0, 8192));
        send_cmd(make_cmd(-32768, -32768, 0, 8192));
        send_cmd(make_cmd(0, 0, 32767, 12345));
        send_cmd(make_cmd(0, 0, -32768, -12345));
        send_cmd(make_cmd(32767, 32767, -32768, 0));
        send_cmd(make_cmd(-32768, 32767, 32767, -8192));
        send_cmd(make_cmd(1, 1, 0, 0));
        send_cmd(make_cmd(-1, -1, 0, 0));
        send_cmd(make_cmd(1, 0, 0, 16383));
        send_cmd(make_cmd(1, 0, 0, 16385));
        send_cmd(make_cmd(32767, 0, 0, 32767));
        send_cmd(make_cmd(12345, -23456, -1, 16383));
        send_cmd(make_cmd(-32768, 0, 1, -16385));
        send_cmd(make_cmd(-32768, -32768, 32767, -24576));

        // Random words: uniform fields, limit-heavy fields, and angles at quadrant edges.
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i % 64 == 0)
            begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            if (i == RANDOM_WORDS / 2)
            begin
                // Hold the sender off until the chain has fully drained.
                cmd_valid <= 1'b0;
                wait_drained();
            end
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                c = owsr_cmd_t'({$urandom, $urandom});
            end
            else if (r < 85)
            begin
                c = make_cmd(edgy_speed(), edgy_speed(), edgy_speed(), angle_t'($urandom));
            end
            else
            begin
                q = $urandom_range(0, 3);
                c = make_cmd(edgy_speed(), edgy_speed(), edgy_speed(),
                             q * 16384 + $urandom_range(0, 6) - 3);
            end
            send_cmd(c);
        end
        cmd_valid <= 1'b0;

        wait_drained();
        repeat (30) @(posedge clk);
        if (sb.errors == 0 && sb.pending_wheels.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

FILE: sim.f
hdl/owsr_pkg.sv
hdl/owsr_cell.sv
hdl/omni_wheel_speed_resolver_unit.sv
tb/sv/tb.sv
